@@ hdl/lec_pkg.sv @@
// Shared types and constants of the line ending converter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lec_pkg;

	localparam int REG_UNITS  = 4;
	localparam int FIFO_DEPTH = 2;

	localparam logic [15:0] UNIT_NUL = 16'h0000;
	localparam logic [15:0] UNIT_LF  = 16'h000A;
	localparam logic [15:0] UNIT_CR  = 16'h000D;
	localparam logic [15:0] UNIT_LS  = 16'h2028;
	localparam logic [15:0] UNIT_PS  = 16'h2029;

	localparam logic [2:0] REG_EOL_LEN    = 3'd0;
	localparam logic [2:0] REG_EOL_UNIT_0 = 3'd1;
	localparam logic [2:0] REG_EOL_UNIT_1 = 3'd2;
	localparam logic [2:0] REG_EOL_UNIT_2 = 3'd3;
	localparam logic [2:0] REG_EOL_UNIT_3 = 3'd4;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_text;
	} item_t;

	typedef struct packed {
		logic [15:0] out_unit;
		logic        has_unit;
		logic        text_done;
		logic [31:0] breaks_replaced;
	} result_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_PASS  = 2'd1,
		ACT_BREAK = 2'd2,
		ACT_END   = 2'd3
	} act_t;

	// flush: a held CR must be emitted as a break before the action
	typedef struct packed {
		logic        flush;
		act_t        act;
		logic [15:0] unit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef logic [REG_UNITS-1:0][15:0] eol_units_t;

endpackage
`default_nettype wire

@@ hdl/lec_front.sv @@
// Front end: accepts code units, tracks a held CR, classifies each beat into a command.
// Depends on lec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lec_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lec_pkg::item_t item,
	input  wire logic           fifo_full,
	output lec_pkg::cmd_t       cmd,
	output logic                cmd_push
);
	import lec_pkg::*;

	logic cr_pending_q;
	logic cr_pending_d;
	logic is_end;

	assign cmd_push = push && !fifo_full;
	assign is_end   = item.end_of_text || (item.code_unit == UNIT_NUL);

	always_comb begin
		cmd.flush    = cr_pending_q;
		cmd.unit     = item.code_unit;
		cmd.act      = ACT_PASS;
		cr_pending_d = 1'b0;
		if (is_end) begin
			cmd.act = ACT_END;
		end else if (cr_pending_q && item.code_unit == UNIT_LF) begin
			// CR LF: the flushed CR stands for the whole pair
			cmd.act = ACT_NONE;
		end else if (item.code_unit == UNIT_CR) begin
			cmd.act      = ACT_NONE;
			cr_pending_d = 1'b1;
		end else if (item.code_unit == UNIT_LF || item.code_unit == UNIT_LS ||
				item.code_unit == UNIT_PS) begin
			cmd.act = ACT_BREAK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_pending_q <= 1'b0;
		end else if (cmd_push) begin
			cr_pending_q <= cr_pending_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/lec_cmd_fifo.sv @@
// Short command queue between front and back end.
// Depends on lec_pkg (cmd_t, fifo_stat_t, FIFO_DEPTH).
`timescale 1ns / 1ps
`default_nettype none
module lec_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lec_pkg::cmd_t wr_cmd,
	input  wire logic          pop,
	output lec_pkg::cmd_t      head,
	output lec_pkg::fifo_stat_t stat
);
	import lec_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == CW'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/lec_back.sv @@
// Back end: executes commands, expands breaks into the replacement units,
// keeps the saturating break count and the output register. Depends on lec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lec_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [2:0]          eol_len,
	input  wire lec_pkg::eol_units_t eol_units,
	input  wire lec_pkg::cmd_t       cmd,
	input  wire logic                cmd_valid,
	output logic                     cmd_take,
	output lec_pkg::result_t         result,
	output logic                     res_valid,
	input  wire logic                res_pop
);
	import lec_pkg::*;

	localparam int IW = $clog2(REG_UNITS);

	logic [IW-1:0] idx_q;
	logic          flush_done_q;
	logic [31:0]   count_q;
	logic          res_valid_q;
	result_t       result_q;

	logic    slot_free;
	logic    in_flush;
	act_t    cur_act;
	logic    load;
	logic    op_done;
	result_t res_d;

	assign slot_free = !res_valid_q || res_pop;
	assign in_flush  = cmd.flush && !flush_done_q;
	assign cur_act   = in_flush ? ACT_BREAK : cmd.act;
	assign cmd_take  = op_done && !in_flush;
	assign res_valid = res_valid_q;
	assign result    = result_q;

	always_comb begin
		load    = 1'b0;
		op_done = 1'b0;
		res_d   = '0;
		if (cmd_valid) begin
			case (cur_act)
				ACT_BREAK: begin
					if (eol_len == 3'd0) begin
						op_done = 1'b1;
					end else if (slot_free) begin
						load           = 1'b1;
						res_d.out_unit = eol_units[idx_q];
						res_d.has_unit = 1'b1;
						op_done        = ((3'({1'b0, idx_q}) + 3'd1) == eol_len);
					end
				end
				ACT_PASS: begin
					if (slot_free) begin
						load           = 1'b1;
						res_d.out_unit = cmd.unit;
						res_d.has_unit = 1'b1;
						op_done        = 1'b1;
					end
				end
				ACT_END: begin
					if (slot_free) begin
						load                  = 1'b1;
						res_d.text_done       = 1'b1;
						res_d.breaks_replaced = count_q;
						op_done               = 1'b1;
					end
				end
				default: begin
					op_done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			flush_done_q <= 1'b0;
			count_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			if (op_done) begin
				idx_q        <= '0;
				flush_done_q <= in_flush;
			end else if (load) begin
				idx_q <= idx_q + IW'(1);
			end
			if (op_done && cur_act == ACT_BREAK && count_q != '1) begin
				count_q <= count_q + 32'd1;
			end else if (op_done && cur_act == ACT_END) begin
				count_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/line_ending_converter.sv @@
// Line ending converter for UTF-16 text: top level with configuration registers.
// Depends on lec_pkg, lec_front, lec_cmd_fifo, lec_back.
//
// Each line break (CR LF, lone CR, LF, U+2028, U+2029) is replaced by up to
// min(eol_len, MAX_EOL, 4) configured units; other units pass unchanged. A
// CR is held until the next unit arrives. A zero unit or end_of_text flushes
// a held CR and yields an end marker with the saturating break count, which
// then restarts at zero. The front end takes one unit per cycle into a
// two-entry command queue while it is not full; the back end drives the
// result register with one result beat per cycle while the held beat is
// popped or the register is empty. A plain unit yields one beat, a break
// its configured units (none for a zero length), a unit after a held CR
// the break and then its own beat. Configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none
module line_ending_converter #(
	parameter int MAX_EOL = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire lec_pkg::item_t   item,
	output logic                  empty,
	input  wire logic             pop,
	output lec_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);
	import lec_pkg::*;

	localparam int LEN_LIMIT = (MAX_EOL < REG_UNITS) ? MAX_EOL : REG_UNITS;

	logic [2:0] eol_len_q;
	eol_units_t eol_units_q;
	logic [2:0] eff_len;

	cmd_t       front_cmd;
	logic       front_push;
	cmd_t       head_cmd;
	fifo_stat_t fifo_stat;
	logic       cmd_take;
	logic       res_valid;

	assign cfg_ready = 1'b1;
	assign full      = fifo_stat.full;
	assign empty     = !res_valid;
	assign eff_len   = (eol_len_q > 3'(LEN_LIMIT)) ? 3'(LEN_LIMIT) : eol_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_len_q   <= 3'd1;
			eol_units_q <= {{(REG_UNITS-1){16'h0000}}, UNIT_LF};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EOL_LEN:    eol_len_q      <= cfg_data[2:0];
				REG_EOL_UNIT_0: eol_units_q[0] <= cfg_data;
				REG_EOL_UNIT_1: eol_units_q[1] <= cfg_data;
				REG_EOL_UNIT_2: eol_units_q[2] <= cfg_data;
				REG_EOL_UNIT_3: eol_units_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	lec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.fifo_full (fifo_stat.full),
		.cmd       (front_cmd),
		.cmd_push  (front_push)
	);

	lec_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wr_cmd (front_cmd),
		.pop    (cmd_take),
		.head   (head_cmd),
		.stat   (fifo_stat)
	);

	lec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eol_len   (eff_len),
		.eol_units (eol_units_q),
		.cmd       (head_cmd),
		.cmd_valid (!fifo_stat.empty),
		.cmd_take  (cmd_take),
		.result    (result),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	// a result beat is either a unit or an end marker, never both
	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.text_done ? (!result.has_unit && result.out_unit == 16'd0)
			: (result.has_unit && result.breaks_replaced == 32'd0)))
		else $error("malformed result beat");

	// the back end only produces beats from queued commands
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && fifo_stat.empty) |=> empty)
		else $error("result appeared without a queued command");

	// the back end never takes a command from an empty queue
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> !fifo_stat.empty)
		else $error("command taken from empty queue");

	// a stalled result beat is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed");

endmodule
`default_nettype wire
